// ===== sv/bxds_pkg.sv =====
package bxds_pkg;

    localparam int DEF_MAX_SOURCE_WIDTH  = 4096;
    localparam int DEF_MAX_SOURCE_HEIGHT = 4096;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CHAN_W    = 8;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 2'd3;

    localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

    // Status from the setup unit to the pixel front end.
    typedef struct packed {
        logic busy;
        logic restart;
    } setup_stat_t;

endpackage

// ===== sv/bxds_setup.sv =====
module bxds_setup
    import bxds_pkg::*;
#(
    parameter int MAX_SOURCE_WIDTH  = DEF_MAX_SOURCE_WIDTH,
    parameter int MAX_SOURCE_HEIGHT = DEF_MAX_SOURCE_HEIGHT,
    localparam int XW = $clog2(MAX_SOURCE_WIDTH + 1),
    localparam int YW = $clog2(MAX_SOURCE_HEIGHT + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output logic [XW-1:0]        sw,
    output logic [YW-1:0]        sh,
    output logic [XW-1:0]        dw,
    output logic [YW-1:0]        dh,
    output logic [XW-1:0]        kx,
    output logic [XW-1:0]        rx,
    output logic [YW-1:0]        ky,
    output logic [YW-1:0]        ry,
    output setup_stat_t          stat
);

    localparam int DN = (XW > YW) ? XW : YW;
    localparam int CW = $clog2(DN + 1);

    logic [CFG_W-1:0] src_w_reg, src_h_reg, tgt_w_reg, tgt_h_reg;
    logic             start_reg;
    logic             busy_reg;
    logic             restart_reg;
    logic [CW-1:0]    cnt_reg;
    logic [DN-1:0]    qx_reg, qy_reg, remx_reg, remy_reg;

    logic [DN:0]      tx, ty;
    logic [DN-1:0]    dvx, dvy;

    always_comb
    begin
        if (src_w_reg == '0)
            sw = XW'(1);
        else if (32'(src_w_reg) > MAX_SOURCE_WIDTH)
            sw = XW'(MAX_SOURCE_WIDTH);
        else
            sw = XW'(src_w_reg);
        if (src_h_reg == '0)
            sh = YW'(1);
        else if (32'(src_h_reg) > MAX_SOURCE_HEIGHT)
            sh = YW'(MAX_SOURCE_HEIGHT);
        else
            sh = YW'(src_h_reg);
        if (tgt_w_reg == '0)
            dw = XW'(1);
        else if (32'(tgt_w_reg) > 32'(sw))
            dw = sw;
        else
            dw = XW'(tgt_w_reg);
        if (tgt_h_reg == '0)
            dh = YW'(1);
        else if (32'(tgt_h_reg) > 32'(sh))
            dh = sh;
        else
            dh = YW'(tgt_h_reg);
    end

    assign dvx = DN'(dw);
    assign dvy = DN'(dh);
    assign tx  = {remx_reg, qx_reg[DN-1]};
    assign ty  = {remy_reg, qy_reg[DN-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg   <= CFG_RESET;
            src_h_reg   <= CFG_RESET;
            tgt_w_reg   <= CFG_RESET;
            tgt_h_reg   <= CFG_RESET;
            start_reg   <= 1'b0;
            busy_reg    <= 1'b0;
            restart_reg <= 1'b0;
            cnt_reg     <= '0;
            qx_reg      <= DN'(1);
            qy_reg      <= DN'(1);
            remx_reg    <= '0;
            remy_reg    <= '0;
        end
        else
        begin
            start_reg   <= 1'b0;
            restart_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SOURCE_WIDTH:  src_w_reg <= cfg_wdata;
                    REG_SOURCE_HEIGHT: src_h_reg <= cfg_wdata;
                    REG_TARGET_WIDTH:  tgt_w_reg <= cfg_wdata;
                    REG_TARGET_HEIGHT: tgt_h_reg <= cfg_wdata;
                    default: ;
                endcase
                start_reg <= 1'b1;
                busy_reg  <= 1'b1;
            end
            else if (start_reg)
            begin
                qx_reg   <= DN'(sw);
                qy_reg   <= DN'(sh);
                remx_reg <= '0;
                remy_reg <= '0;
                cnt_reg  <= CW'(DN);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg    <= 1'b0;
                    restart_reg <= 1'b1;
                end
                else
                begin
                    // one restoring step for each ratio
                    if (tx >= {1'b0, dvx})
                    begin
                        remx_reg <= DN'(tx - {1'b0, dvx});
                        qx_reg   <= {qx_reg[DN-2:0], 1'b1};
                    end
                    else
                    begin
                        remx_reg <= tx[DN-1:0];
                        qx_reg   <= {qx_reg[DN-2:0], 1'b0};
                    end
                    if (ty >= {1'b0, dvy})
                    begin
                        remy_reg <= DN'(ty - {1'b0, dvy});
                        qy_reg   <= {qy_reg[DN-2:0], 1'b1};
                    end
                    else
                    begin
                        remy_reg <= ty[DN-1:0];
                        qy_reg   <= {qy_reg[DN-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - CW'(1);
                end
            end
        end
    end

    assign kx = qx_reg[XW-1:0];
    assign rx = remx_reg[XW-1:0];
    assign ky = qy_reg[YW-1:0];
    assign ry = remy_reg[YW-1:0];
    // hold input off through the restart cycle too, so no beat is taken and dropped
    assign stat.busy    = busy_reg || start_reg || restart_reg || cfg_we;
    assign stat.restart = restart_reg;

endmodule

// ===== sv/bxds_front.sv =====
module bxds_front
    import bxds_pkg::*;
#(
    parameter int MAX_SOURCE_WIDTH  = DEF_MAX_SOURCE_WIDTH,
    parameter int MAX_SOURCE_HEIGHT = DEF_MAX_SOURCE_HEIGHT,
    localparam int XW = $clog2(MAX_SOURCE_WIDTH + 1),
    localparam int YW = $clog2(MAX_SOURCE_HEIGHT + 1),
    localparam int AW = $clog2(MAX_SOURCE_WIDTH),
    localparam int SW = XW + YW + CHAN_W,
    localparam int PW = 4 * SW + XW + YW + 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [4*CHAN_W-1:0]  s_tdata,
    input  logic [XW-1:0]        sw,
    input  logic [YW-1:0]        sh,
    input  logic [XW-1:0]        dw,
    input  logic [YW-1:0]        dh,
    input  logic [XW-1:0]        kx,
    input  logic [XW-1:0]        rx,
    input  logic [YW-1:0]        ky,
    input  logic [YW-1:0]        ry,
    input  setup_stat_t          stat,
    input  logic                 q_full,
    output logic                 q_push,
    output logic [PW-1:0]        q_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_ACC  = 1'b1;

    logic                state_reg;
    logic [4*CHAN_W-1:0] pix_reg;
    logic [4*SW-1:0]     mem [MAX_SOURCE_WIDTH];
    logic [4*SW-1:0]     rd_reg;
    logic [4*SW-1:0]     sums_next;

    logic [XW-1:0] col_reg, oc_reg, x0_reg, x1_reg, xr_reg;
    logic [YW-1:0] row_reg, orow_reg, y0_reg, y1_reg, yr_reg;

    logic          accept, first, col_end, row_last, frame_last;
    logic [XW:0]   col_inc, xr_sum;
    logic [YW:0]   row_inc, yr_sum;
    logic [XW-1:0] x1_step, xr_step;
    logic [YW-1:0] y1_step, yr_step;

    assign s_tready = (state_reg == ST_IDLE) && !stat.busy && !q_full;
    assign accept   = s_tvalid && s_tready;

    assign col_inc    = {1'b0, col_reg} + (XW+1)'(1);
    assign row_inc    = {1'b0, row_reg} + (YW+1)'(1);
    assign first      = (row_reg == y0_reg) && (col_reg == x0_reg);
    assign col_end    = col_inc >= {1'b0, x1_reg};
    assign row_last   = row_inc >= {1'b0, y1_reg};
    assign frame_last = ({1'b0, oc_reg} + (XW+1)'(1) >= {1'b0, dw})
                     && ({1'b0, orow_reg} + (YW+1)'(1) >= {1'b0, dh});

    // next region edge: add quotient, carry the remainder
    always_comb
    begin
        xr_sum = {1'b0, xr_reg} + {1'b0, rx};
        if (xr_sum >= {1'b0, dw})
        begin
            xr_step = XW'(xr_sum - {1'b0, dw});
            x1_step = x1_reg + kx + XW'(1);
        end
        else
        begin
            xr_step = xr_sum[XW-1:0];
            x1_step = x1_reg + kx;
        end
        yr_sum = {1'b0, yr_reg} + {1'b0, ry};
        if (yr_sum >= {1'b0, dh})
        begin
            yr_step = YW'(yr_sum - {1'b0, dh});
            y1_step = y1_reg + ky + YW'(1);
        end
        else
        begin
            yr_step = yr_sum[YW-1:0];
            y1_step = y1_reg + ky;
        end
    end

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            if (first)
                sums_next[c*SW +: SW] = SW'(pix_reg[c*CHAN_W +: CHAN_W]);
            else
                sums_next[c*SW +: SW] = rd_reg[c*SW +: SW]
                                      + SW'(pix_reg[c*CHAN_W +: CHAN_W]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            rd_reg <= mem[oc_reg[AW-1:0]];
        if (state_reg == ST_ACC)
            mem[oc_reg[AW-1:0]] <= sums_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            pix_reg <= s_tdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            oc_reg    <= '0;
            orow_reg  <= '0;
            x0_reg    <= '0;
            x1_reg    <= XW'(1);
            xr_reg    <= '0;
            y0_reg    <= '0;
            y1_reg    <= YW'(1);
            yr_reg    <= '0;
        end
        else if (stat.restart)
        begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            oc_reg    <= '0;
            orow_reg  <= '0;
            x0_reg    <= '0;
            x1_reg    <= kx;
            xr_reg    <= rx;
            y0_reg    <= '0;
            y1_reg    <= ky;
            yr_reg    <= ry;
        end
        else if (state_reg == ST_IDLE)
        begin
            if (accept)
                state_reg <= ST_ACC;
        end
        else
        begin
            state_reg <= ST_IDLE;
            col_reg   <= col_inc[XW-1:0];
            if (col_end)
            begin
                oc_reg <= oc_reg + XW'(1);
                x0_reg <= x1_reg;
                x1_reg <= x1_step;
                xr_reg <= xr_step;
            end
            if (col_inc >= {1'b0, sw})
            begin
                // end of row: rewind the column regions
                col_reg <= '0;
                oc_reg  <= '0;
                x0_reg  <= '0;
                x1_reg  <= kx;
                xr_reg  <= rx;
                row_reg <= row_inc[YW-1:0];
                if (row_last)
                begin
                    orow_reg <= orow_reg + YW'(1);
                    y0_reg   <= y1_reg;
                    y1_reg   <= y1_step;
                    yr_reg   <= yr_step;
                end
                if (row_inc >= {1'b0, sh})
                begin
                    row_reg  <= '0;
                    orow_reg <= '0;
                    y0_reg   <= '0;
                    y1_reg   <= ky;
                    yr_reg   <= ry;
                end
            end
        end
    end

    assign q_push = (state_reg == ST_ACC) && col_end && row_last;
    assign q_data = {frame_last, YW'(y1_reg - y0_reg), XW'(x1_reg - x0_reg), sums_next};

    a_acc_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_ACC || stat.restart))
        else $error("accepted beat did not enter accumulate");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("push into full queue");
    a_region_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC) |-> (x1_reg > col_reg && y1_reg > row_reg))
        else $error("position beyond its region end");

endmodule

// ===== sv/bxds_fifo.sv =====
module bxds_fifo
    import bxds_pkg::*;
#(
    parameter int W = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         empty,
    output logic         full
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]     buf_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign rdata = buf_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (32'(wr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_reg + PTR_W'(1);
            if (pop)
                rd_reg <= (32'(rd_reg) == QUEUE_DEPTH - 1) ? '0 : rd_reg + PTR_W'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

endmodule

// ===== sv/bxds_back.sv =====
module bxds_back
    import bxds_pkg::*;
#(
    parameter int MAX_SOURCE_WIDTH  = DEF_MAX_SOURCE_WIDTH,
    parameter int MAX_SOURCE_HEIGHT = DEF_MAX_SOURCE_HEIGHT,
    localparam int XW = $clog2(MAX_SOURCE_WIDTH + 1),
    localparam int YW = $clog2(MAX_SOURCE_HEIGHT + 1),
    localparam int SW = XW + YW + CHAN_W,
    localparam int PW = 4 * SW + XW + YW + 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  logic [PW-1:0]       q_data,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [4*CHAN_W-1:0] m_tdata,
    output logic                m_tlast
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]          state_reg;
    logic [PW-1:0]       job_reg;
    logic [4*SW-1:0]     rem_reg;
    logic [SW-1:0]       div_reg;
    logic [4*CHAN_W-1:0] quo_reg;
    logic [2:0]          step_reg;
    logic [XW+YW-1:0]    area;

    assign q_pop = (state_reg == ST_IDLE) && !q_empty;
    assign area  = job_reg[4*SW +: XW] * job_reg[4*SW+XW +: YW];

    always_ff @(posedge clk)
    begin
        if (q_pop)
            job_reg <= q_data;
        if (state_reg == ST_MUL)
        begin
            rem_reg <= job_reg[4*SW-1:0];
            div_reg <= SW'(area) << (CHAN_W - 1);
        end
        else if (state_reg == ST_DIV)
        begin
            // one quotient bit per channel, high bit first
            for (int c = 0; c < 4; c++)
            begin
                if (rem_reg[c*SW +: SW] >= div_reg)
                begin
                    rem_reg[c*SW +: SW] <= rem_reg[c*SW +: SW] - div_reg;
                    quo_reg[c*CHAN_W +: CHAN_W] <=
                        {quo_reg[c*CHAN_W +: CHAN_W-1], 1'b1};
                end
                else
                begin
                    quo_reg[c*CHAN_W +: CHAN_W] <=
                        {quo_reg[c*CHAN_W +: CHAN_W-1], 1'b0};
                end
            end
            div_reg <= div_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                    if (q_pop)
                        state_reg <= ST_MUL;
                ST_MUL:
                begin
                    step_reg  <= 3'(CHAN_W - 1);
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    step_reg <= step_reg - 3'd1;
                    if (step_reg == '0)
                        state_reg <= ST_OUT;
                end
                ST_OUT:
                    if (m_tready)
                        state_reg <= ST_IDLE;
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = quo_reg;
    assign m_tlast  = job_reg[PW-1];

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg == ST_MUL))
        else $error("queue pop without starting a job");
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |=> (state_reg == ST_DIV && step_reg == 3'(CHAN_W - 1)))
        else $error("divide did not start with full step count");

endmodule

// ===== sv/box_average_image_downscaler.sv =====
// Area-average RGBA downscaler.
// Input: one source pixel at a time, set by the read-modify-write of the
// column sum memory (read, then add and write in the next cycle); input also stalls
// while the queue is full or the setup unit is busy. A finished region leaves the output
// register after the queue, a multiply state and 8 restoring divide steps, plus any output stall.
// Reset and every register write restart the frame; a write blocks input until the restart.
module box_average_image_downscaler
    import bxds_pkg::*;
#(
    parameter int MAX_SOURCE_WIDTH  = DEF_MAX_SOURCE_WIDTH,
    parameter int MAX_SOURCE_HEIGHT = DEF_MAX_SOURCE_HEIGHT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,  // in_red, in_green, in_blue, in_alpha
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,  // out_red, out_green, out_blue, out_alpha
    output logic                 m_tlast
);

    localparam int XW = $clog2(MAX_SOURCE_WIDTH + 1);
    localparam int YW = $clog2(MAX_SOURCE_HEIGHT + 1);
    localparam int SW = XW + YW + CHAN_W;
    localparam int PW = 4 * SW + XW + YW + 1;

    logic [XW-1:0] sw, dw, kx, rx;
    logic [YW-1:0] sh, dh, ky, ry;
    setup_stat_t   stat;
    logic          q_push, q_pop, q_empty, q_full;
    logic [PW-1:0] q_wdata, q_rdata;

    bxds_setup #(
        .MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH),
        .MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT)
    ) u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .sw        (sw),
        .sh        (sh),
        .dw        (dw),
        .dh        (dh),
        .kx        (kx),
        .rx        (rx),
        .ky        (ky),
        .ry        (ry),
        .stat      (stat)
    );

    bxds_front #(
        .MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH),
        .MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .sw       (sw),
        .sh       (sh),
        .dw       (dw),
        .dh       (dh),
        .kx       (kx),
        .rx       (rx),
        .ky       (ky),
        .ry       (ry),
        .stat     (stat),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    bxds_fifo #(
        .W (PW)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty),
        .full  (q_full)
    );

    bxds_back #(
        .MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH),
        .MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (q_rdata),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
